// ----- hw/rtl/ubd_pkg.sv -----
`default_nettype none

package ubd_pkg;

  // Field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned NeedW  = 3;
  localparam int unsigned TakenW = 2;
  localparam int unsigned CntW   = 3;

  // Replacement character U+FFFD
  localparam logic [CpW-1:0] ReplCp = 21'h00FFFD;

  // Lead byte prefixes
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  // Continuations still needed after each lead
  localparam logic [NeedW-1:0] Need2 = 3'd1;
  localparam logic [NeedW-1:0] Need3 = 3'd2;
  localparam logic [NeedW-1:0] Need4 = 3'd3;

  // Work for one byte: repl_cnt replacements, then an optional decoded value
  typedef struct packed {
    logic [CntW-1:0] repl_cnt;
    logic            has_val;
    logic [CpW-1:0]  cp;
    logic            str_end;
  } desc_t;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_byte_stream_decoder_unit.sv -----
// A byte's descriptor is written into the queue, then loaded into the output register.
// Throughput: one byte per cycle while each byte yields at most one result and
// out_stall_i is low; a byte yielding several results (up to four) holds the output
// stage until all have gone out, and the front keeps accepting until the queue is full.
// Reset: sequence state cleared, queue empty, no result valid.
`default_nettype none

module utf8_byte_stream_decoder_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [ubd_pkg::ByteW-1:0] byte_in_i,
  input  wire logic                      string_end_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic [ubd_pkg::CpW-1:0]        code_point_o,
  output logic                           is_replacement_o,
  output logic                           run_last_o,
  output logic                           string_last_o
);

  logic           push, pop, full, empty;
  ubd_pkg::desc_t push_desc, head;

  // Front: decode bytes into result words
  ubd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .byte_in_i    (byte_in_i),
    .string_end_i (string_end_i),
    .full_i       (full),
    .push_o       (push),
    .push_desc_o  (push_desc)
  );

  // Queue between front and back
  ubd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .pop_i       (pop),
    .full_o      (full),
    .empty_o     (empty),
    .head_o      (head)
  );

  // Back: emit the results of each word
  ubd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_point_o     (code_point_o),
    .is_replacement_o (is_replacement_o),
    .run_last_o       (run_last_o),
    .string_last_o    (string_last_o)
  );

`ifndef SYNTH
  // front never pushes into a full queue
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("push into full queue");

  // every queued word carries between one and four results
  a_word_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (head.repl_cnt != '0 || head.has_val) &&
               (head.repl_cnt + ubd_pkg::CntW'(head.has_val) <= ubd_pkg::CntW'(4)))
    else $error("queued word has bad result count");

  // end of string only on the last result of a byte
  a_str_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_last_o |-> run_last_o)
    else $error("string_last without run_last");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/ubd_front.sv -----
`default_nettype none

module ubd_front (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic [ubd_pkg::ByteW-1:0] byte_in_i,
  input  wire logic                      string_end_i,
  input  wire logic                      full_i,
  output logic                           push_o,
  output ubd_pkg::desc_t                 push_desc_o
);

  logic [ubd_pkg::CpW-1:0]    pv_q, pv_d;
  logic [ubd_pkg::NeedW-1:0]  need_q, need_d;
  logic [ubd_pkg::TakenW-1:0] taken_q, taken_d;
  logic [ubd_pkg::CntW-1:0]   rc;
  logic                       hv;
  logic [ubd_pkg::CpW-1:0]    cp;
  logic                       as_lead;
  logic [ubd_pkg::CpW-1:0]    pv_ext;
  logic                       accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign pv_ext     = {pv_q[ubd_pkg::CpW-7:0], byte_in_i[5:0]};

  // Classify the byte against the open sequence and work out its results
  always_comb begin
    pv_d    = pv_q;
    need_d  = need_q;
    taken_d = taken_q;
    rc      = '0;
    hv      = 1'b0;
    cp      = '0;
    as_lead = 1'b1;

    if (need_q != '0) begin
      if (byte_in_i[7:6] == ubd_pkg::ContTag) begin
        as_lead = 1'b0;
        if (need_q == ubd_pkg::NeedW'(1)) begin
          hv      = 1'b1;
          cp      = pv_ext;
          pv_d    = '0;
          need_d  = '0;
          taken_d = '0;
        end else begin
          pv_d    = pv_ext;
          need_d  = need_q - ubd_pkg::NeedW'(1);
          taken_d = taken_q + ubd_pkg::TakenW'(1);
        end
      end else begin
        // broken sequence: lead plus continuations taken
        rc      = ubd_pkg::CntW'(taken_q) + ubd_pkg::CntW'(1);
        pv_d    = '0;
        need_d  = '0;
        taken_d = '0;
      end
    end

    if (as_lead) begin
      if (!byte_in_i[7]) begin
        hv = 1'b1;
        cp = ubd_pkg::CpW'(byte_in_i);
      end else if (byte_in_i[7:5] == ubd_pkg::Lead2Tag) begin
        pv_d    = ubd_pkg::CpW'(byte_in_i[4:0]);
        need_d  = ubd_pkg::Need2;
        taken_d = '0;
      end else if (byte_in_i[7:4] == ubd_pkg::Lead3Tag) begin
        pv_d    = ubd_pkg::CpW'(byte_in_i[3:0]);
        need_d  = ubd_pkg::Need3;
        taken_d = '0;
      end else if (byte_in_i[7:3] == ubd_pkg::Lead4Tag) begin
        pv_d    = ubd_pkg::CpW'(byte_in_i[2:0]);
        need_d  = ubd_pkg::Need4;
        taken_d = '0;
      end else begin
        rc = rc + ubd_pkg::CntW'(1);
      end
    end

    // truncated string: flush what is still open
    if (string_end_i && need_d != '0) begin
      rc      = rc + ubd_pkg::CntW'(taken_d) + ubd_pkg::CntW'(1);
      pv_d    = '0;
      need_d  = '0;
      taken_d = '0;
    end
  end

  assign push_o               = accept && (rc != '0 || hv);
  assign push_desc_o.repl_cnt = rc;
  assign push_desc_o.has_val  = hv;
  assign push_desc_o.cp       = cp;
  assign push_desc_o.str_end  = string_end_i;

  // Sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q    <= '0;
      need_q  <= '0;
      taken_q <= '0;
    end else if (accept) begin
      pv_q    <= pv_d;
      need_q  <= need_d;
      taken_q <= taken_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ubd_queue.sv -----
`default_nettype none

module ubd_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ubd_pkg::desc_t push_desc_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                empty_o,
  output ubd_pkg::desc_t      head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned FillW = $clog2(Depth + 1);

  ubd_pkg::desc_t   mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FillW-1:0] fill_q;
  logic             do_push, do_pop;

  assign full_o  = fill_q == FillW'(Depth);
  assign empty_o = fill_q == '0;
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + FillW'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - FillW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/ubd_back.sv -----
`default_nettype none

module ubd_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    empty_i,
  input  wire ubd_pkg::desc_t          head_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output logic [ubd_pkg::CpW-1:0]      code_point_o,
  output logic                         is_replacement_o,
  output logic                         run_last_o,
  output logic                         string_last_o
);

  logic [ubd_pkg::CntW-1:0] idx_q;
  logic [ubd_pkg::CntW-1:0] total;
  logic                     is_repl, is_final, load;
  logic                     out_valid_q;
  logic [ubd_pkg::CpW-1:0]  cp_q;
  logic                     repl_q, run_last_q, str_last_q;

  // Which result of the head word goes out next
  assign total    = head_i.repl_cnt + ubd_pkg::CntW'(head_i.has_val);
  assign is_repl  = idx_q < head_i.repl_cnt;
  assign is_final = (idx_q + ubd_pkg::CntW'(1)) == total;
  assign load     = !empty_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && is_final;

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_final ? '0 : idx_q + ubd_pkg::CntW'(1);
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q       <= is_repl ? ubd_pkg::ReplCp : head_i.cp;
      repl_q     <= is_repl;
      run_last_q <= is_final;
      str_last_q <= is_final && head_i.str_end;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_point_o     = cp_q;
  assign is_replacement_o = repl_q;
  assign run_last_o       = run_last_q;
  assign string_last_o    = str_last_q;

endmodule

`default_nettype wire

// ----- verif/utf8_byte_stream_decoder_unit_tb.sv -----
`timescale 1ns / 1ps

module utf8_byte_stream_decoder_unit_tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBytes  = 243;
  // cycles with no idling on either side
  localparam int unsigned CalmFrom   = 150;
  localparam int unsigned CalmTo     = 400;

  typedef struct packed {
    logic [ubd_pkg::ByteW-1:0] b;
    logic                      str_end;
  } byte_word_t;

  typedef struct packed {
    logic [ubd_pkg::CpW-1:0] cp;
    logic                    repl;
    logic                    run_last;
    logic                    str_last;
  } cp_word_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic [ubd_pkg::ByteW-1:0] byte_in_i = '0;
  logic                      string_end_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [ubd_pkg::CpW-1:0]   code_point_o;
  logic                      is_replacement_o;
  logic                      run_last_o;
  logic                      string_last_o;

  byte_word_t byte_feed[$];
  cp_word_t   decoded_q[$];
  cp_word_t   step_cps[$];

  // decoder state mirror
  logic [ubd_pkg::CpW-1:0]    seq_value = '0;
  logic [ubd_pkg::NeedW-1:0]  seq_need  = '0;
  logic [ubd_pkg::TakenW-1:0] seq_taken = '0;

  logic in_fire = 1'b0;
  int   cycles = 0;
  int   fails = 0;

  utf8_byte_stream_decoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_in_i       (byte_in_i),
    .string_end_i    (string_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_point_o    (code_point_o),
    .is_replacement_o(is_replacement_o),
    .run_last_o      (run_last_o),
    .string_last_o   (string_last_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic idle_now();
    if (cycles >= CalmFrom && cycles < CalmTo) return 1'b0;
    return $urandom_range(0, 99) < 26;
  endfunction

  task automatic push_cp(input logic [ubd_pkg::CpW-1:0] cp, input logic repl);
    cp_word_t w;
    w.cp = cp;
    w.repl = repl;
    w.run_last = 1'b0;
    w.str_last = 1'b0;
    step_cps = {step_cps, w};
  endtask

  // one replacement for the lead plus one per continuation taken
  task automatic flush_seq();
    for (int k = 0; k <= int'(seq_taken); k++) push_cp(ubd_pkg::ReplCp, 1'b1);
    seq_value = '0;
    seq_need  = '0;
    seq_taken = '0;
  endtask

  // Expected code points for one accepted byte
  task automatic decode_byte(input logic [ubd_pkg::ByteW-1:0] b, input logic str_end);
    logic as_lead;
    cp_word_t w;
    as_lead = 1'b1;
    step_cps.delete();
    if (seq_need != '0) begin
      if (b[7:6] == ubd_pkg::ContTag) begin
        as_lead = 1'b0;
        seq_value = {seq_value[ubd_pkg::CpW-7:0], b[5:0]};
        seq_need = seq_need - ubd_pkg::NeedW'(1);
        if (seq_need == '0) begin
          push_cp(seq_value, 1'b0);
          seq_value = '0;
          seq_taken = '0;
        end else begin
          seq_taken = seq_taken + ubd_pkg::TakenW'(1);
        end
      end else begin
        flush_seq();
      end
    end
    if (as_lead) begin
      if (b[7] == 1'b0) begin
        push_cp({13'd0, b}, 1'b0);
      end else if (b[7:5] == ubd_pkg::Lead2Tag) begin
        seq_value = {16'd0, b[4:0]};
        seq_need  = ubd_pkg::Need2;
        seq_taken = '0;
      end else if (b[7:4] == ubd_pkg::Lead3Tag) begin
        seq_value = {17'd0, b[3:0]};
        seq_need  = ubd_pkg::Need3;
        seq_taken = '0;
      end else if (b[7:3] == ubd_pkg::Lead4Tag) begin
        seq_value = {18'd0, b[2:0]};
        seq_need  = ubd_pkg::Need4;
        seq_taken = '0;
      end else begin
        push_cp(ubd_pkg::ReplCp, 1'b1);
      end
    end
    // string ends inside a sequence
    if (str_end && seq_need != '0) flush_seq();
    for (int k = 0; k < step_cps.size(); k++) begin
      w = step_cps[k];
      if (k == step_cps.size() - 1) begin
        w.run_last = 1'b1;
        w.str_last = str_end;
      end
      decoded_q = {decoded_q, w};
    end
  endtask

  task automatic feed(input logic [ubd_pkg::ByteW-1:0] b, input logic str_end);
    byte_word_t w;
    w.b = b;
    w.str_end = str_end;
    byte_feed = {byte_feed, w};
  endtask

  // Driver: next input word at the falling edge, held while stalled
  always @(negedge clk_i) begin : drive_proc
    byte_word_t w;
    if (rst_ni) begin
      if (!in_valid_i || in_fire) begin
        if (byte_feed.size() != 0 && !idle_now()) begin
          w = byte_feed.pop_front();
          in_valid_i   <= 1'b1;
          byte_in_i    <= w.b;
          string_end_i <= w.str_end;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= idle_now();
    end
  end

  // Monitor: check output words, then predict from the accepted input word
  always @(posedge clk_i) begin : mon_proc
    cp_word_t w;
    cycles <= cycles + 1;
    in_fire <= in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected code point %0h", code_point_o);
        fails++;
      end else begin
        w = decoded_q.pop_front();
        if (code_point_o !== w.cp) begin
          $error("code_point: expected %0h, actual %0h", w.cp, code_point_o);
          fails++;
        end
        if (is_replacement_o !== w.repl) begin
          $error("is_replacement: expected %0b, actual %0b", w.repl, is_replacement_o);
          fails++;
        end
        if (run_last_o !== w.run_last) begin
          $error("run_last: expected %0b, actual %0b", w.run_last, run_last_o);
          fails++;
        end
        if (string_last_o !== w.str_last) begin
          $error("string_last: expected %0b, actual %0b", w.str_last, string_last_o);
          fails++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o) decode_byte(byte_in_i, string_end_i);
  end

  // Watchdog
  always @(posedge clk_i) begin
    if (cycles > CycleLimit) begin
      $display("utf8_byte_stream_decoder_unit verification failed");
      $finish;
    end
  end

  initial begin
    int n;
    int len;
    int cnt;
    int kind;
    logic [7:0] rb;
    logic [7:0] seq [4];

    // Directed: ASCII extremes, each sequence length, largest four-byte payload
    feed(8'h00, 1'b1);
    feed(8'h7F, 1'b0);
    feed(8'hC2, 1'b0); feed(8'hA9, 1'b0);
    feed(8'hE2, 1'b0); feed(8'h82, 1'b0); feed(8'hAC, 1'b1);
    feed(8'hF7, 1'b0); feed(8'hBF, 1'b0); feed(8'hBF, 1'b0); feed(8'hBF, 1'b0);
    // stray continuations and invalid leads
    feed(8'h80, 1'b0);
    feed(8'hBF, 1'b1);
    feed(8'hF8, 1'b0);
    feed(8'hFF, 1'b0);
    // broken sequence, offending byte starts a new one that completes
    feed(8'hF0, 1'b0); feed(8'h9F, 1'b0); feed(8'h98, 1'b0);
    feed(8'hC3, 1'b0); feed(8'hA9, 1'b0);
    // truncated string
    feed(8'hE2, 1'b0); feed(8'h82, 1'b1);
    // broken sequence and a new lead cut by the string end: four results
    feed(8'hF0, 1'b0); feed(8'h9F, 1'b0); feed(8'h98, 1'b0); feed(8'hF0, 1'b1);

    // Random: mostly well-formed characters, some cut short, some noise
    n = 0;
    while (n < RandBytes) begin
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      rb = 8'($urandom);
      case (len)
        1: seq[0] = {1'b0, rb[6:0]};
        2: seq[0] = {ubd_pkg::Lead2Tag, rb[4:0]};
        3: seq[0] = {ubd_pkg::Lead3Tag, rb[3:0]};
        default: seq[0] = {ubd_pkg::Lead4Tag, rb[2:0]};
      endcase
      for (int k = 1; k < 4; k++) begin
        rb = 8'($urandom);
        seq[k] = {ubd_pkg::ContTag, rb[5:0]};
      end
      if (kind < 60) cnt = len;
      else if (kind < 80) cnt = (len > 1) ? $urandom_range(1, len - 1) : 1;
      else begin
        seq[0] = 8'($urandom);
        cnt = 1;
      end
      for (int k = 0; k < cnt; k++) feed(seq[k], $urandom_range(0, 7) == 0);
      n += cnt;
    end

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (byte_feed.size() != 0 || in_valid_i) @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fails == 0) begin
      $display("utf8_byte_stream_decoder_unit verification clean");
    end else begin
      $display("utf8_byte_stream_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

// ----- utf8_byte_stream_decoder_unit.f -----
hw/rtl/ubd_pkg.sv
hw/rtl/ubd_front.sv
hw/rtl/ubd_queue.sv
hw/rtl/ubd_back.sv
hw/rtl/utf8_byte_stream_decoder_unit.sv
verif/utf8_byte_stream_decoder_unit_tb.sv
